FILE: rtl/rcg_pkg.sv
// Shared constants, control/status types and prefix helpers for the capture gate.
package rcg_pkg;

    localparam int RING_DEPTH_DEF      = 32;
    localparam int OBS_DEPTH_DEF       = 16;
    localparam int MAX_FRAME_BYTES_DEF = 255;

    localparam int PREFIX_BYTES = 6;
    localparam int LEN_W        = 8;
    localparam int PFX_W        = 8 * PREFIX_BYTES;
    localparam int PLEN_W       = 3;
    localparam int CNT_W        = 32;
    localparam int SLOT_W       = 5;
    localparam int OCC_W        = 6;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic load;
        logic scan_step;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic need_scan;
        logic scan_last;
        logic out_free;
    } t_status;

    // keeps the first plen bytes of the prefix
    function automatic logic [PFX_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
        logic [PFX_W-1:0] m;
        m = '0;
        for (int b = 0; b < PREFIX_BYTES; b++) begin
            m[b*8 +: 8] = (PLEN_W'(b) < plen) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

FILE: rtl/rcg_in_if.sv
// Input channel: one captured frame per transaction.
interface rcg_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic                        coded_frame;
    logic [rcg_pkg::LEN_W-1:0]   frame_length;
    logic [rcg_pkg::PFX_W-1:0]   prefix_bytes;

    modport source (output valid, mode, coded_frame, frame_length, prefix_bytes,
                    input ready);
    modport sink   (input valid, mode, coded_frame, frame_length, prefix_bytes,
                    output ready);
endinterface

FILE: rtl/rcg_out_if.sv
// Output channel: one gate decision with ring position and statistics per transaction.
interface rcg_out_if;
    logic                        valid;
    logic                        ready;
    logic                        decision;
    logic [rcg_pkg::SLOT_W-1:0]  write_slot;
    logic                        evicted;
    logic [rcg_pkg::OCC_W-1:0]   occupancy;
    logic [rcg_pkg::CNT_W-1:0]   inserted_total;
    logic [rcg_pkg::CNT_W-1:0]   evicted_total;
    logic [rcg_pkg::CNT_W-1:0]   rejected_total;
    logic [rcg_pkg::LEN_W-1:0]   length_min;
    logic [rcg_pkg::LEN_W-1:0]   length_max;
    logic [rcg_pkg::CNT_W-1:0]   length_sum;
    logic [rcg_pkg::CNT_W-1:0]   uncoded_total;
    logic [rcg_pkg::CNT_W-1:0]   coded_total;

    modport source (output valid, decision, write_slot, evicted, occupancy,
                    inserted_total, evicted_total, rejected_total, length_min,
                    length_max, length_sum, uncoded_total, coded_total,
                    input ready);
    modport sink   (input valid, decision, write_slot, evicted, occupancy,
                    inserted_total, evicted_total, rejected_total, length_min,
                    length_max, length_sum, uncoded_total, coded_total,
                    output ready);
endinterface

FILE: rtl/rcg_ctrl.sv
// Sequencer for accept, prefix scan, drain and commit of one frame.
module rcg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rcg_pkg::t_status i_st,
    output rcg_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_st.in_valid) begin
                        r_state <= i_st.need_scan ? S_SCAN : S_COMMIT;
                    end
                end
                S_SCAN: begin
                    if (i_st.scan_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_COMMIT;
                S_COMMIT: begin
                    if (i_st.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no transaction is taken while reset is held
    always_comb begin
        o_cmd           = '0;
        o_cmd.in_ready  = (r_state == S_IDLE) && i_rst_n;
        o_cmd.load      = (r_state == S_IDLE) && i_rst_n && i_st.in_valid;
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.commit    = (r_state == S_COMMIT) && i_st.out_free;
    end

endmodule

FILE: rtl/rcg_dp.sv
// Datapath: frame capture, prefix store and scan, ring position and statistics.
module rcg_dp #(
    parameter int RING_DEPTH      = rcg_pkg::RING_DEPTH_DEF,
    parameter int OBS_DEPTH       = rcg_pkg::OBS_DEPTH_DEF,
    parameter int MAX_FRAME_BYTES = rcg_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rcg_pkg::t_cmd               i_cmd,
    output rcg_pkg::t_status            o_st,
    input  logic                        i_in_valid,
    input  logic                        i_mode,
    input  logic                        i_coded_frame,
    input  logic [rcg_pkg::LEN_W-1:0]   i_frame_length,
    input  logic [rcg_pkg::PFX_W-1:0]   i_prefix_bytes,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_decision,
    output logic [rcg_pkg::SLOT_W-1:0]  o_write_slot,
    output logic                        o_evicted,
    output logic [rcg_pkg::OCC_W-1:0]   o_occupancy,
    output logic [rcg_pkg::CNT_W-1:0]   o_inserted_total,
    output logic [rcg_pkg::CNT_W-1:0]   o_evicted_total,
    output logic [rcg_pkg::CNT_W-1:0]   o_rejected_total,
    output logic [rcg_pkg::LEN_W-1:0]   o_length_min,
    output logic [rcg_pkg::LEN_W-1:0]   o_length_max,
    output logic [rcg_pkg::CNT_W-1:0]   o_length_sum,
    output logic [rcg_pkg::CNT_W-1:0]   o_uncoded_total,
    output logic [rcg_pkg::CNT_W-1:0]   o_coded_total
);

    localparam int OW  = (OBS_DEPTH > 1) ? $clog2(OBS_DEPTH) : 1;
    localparam int FW  = $clog2(OBS_DEPTH + 1);
    localparam int RW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FLW = $clog2(RING_DEPTH + 1);
    localparam int EW  = rcg_pkg::PLEN_W + rcg_pkg::PFX_W;

    // captured frame
    logic                          r_gated;
    logic                          r_coded;
    logic [rcg_pkg::LEN_W-1:0]     r_len;
    logic [rcg_pkg::PLEN_W-1:0]    r_plen;
    logic [rcg_pkg::PFX_W-1:0]     r_pfx;

    // prefix store and scan
    logic [EW-1:0]                 r_seen_mem [OBS_DEPTH];
    logic [OW-1:0]                 r_seen_next;
    logic [FW-1:0]                 r_seen_filled;
    logic [OW-1:0]                 r_idx;
    logic                          r_cmp_vld;
    logic                          r_hit;
    logic [rcg_pkg::PLEN_W-1:0]    r_rd_len;
    logic [rcg_pkg::PFX_W-1:0]     r_rd_pfx;

    // ring and statistics
    logic [RW-1:0]                 r_ring_next;
    logic [FLW-1:0]                r_ring_fill;
    logic [rcg_pkg::CNT_W-1:0]     r_adm_cnt;
    logic [rcg_pkg::CNT_W-1:0]     r_ovw_cnt;
    logic [rcg_pkg::CNT_W-1:0]     r_rej_cnt;
    logic [rcg_pkg::LEN_W-1:0]     r_shortest;
    logic [rcg_pkg::LEN_W-1:0]     r_longest;
    logic [rcg_pkg::CNT_W-1:0]     r_byte_sum;
    logic [rcg_pkg::CNT_W-1:0]     r_plain_cnt;
    logic [rcg_pkg::CNT_W-1:0]     r_manch_cnt;

    // result register
    logic                          r_out_valid;
    logic                          r_decision;
    logic [rcg_pkg::SLOT_W-1:0]    r_slot;
    logic                          r_evicted;

    logic [rcg_pkg::LEN_W-1:0]     len_in;
    logic [rcg_pkg::PLEN_W-1:0]    plen_in;
    logic                          admit;
    logic                          ring_full;
    logic [rcg_pkg::CNT_W-1:0]     n_adm_cnt;

    always_comb begin
        len_in = (32'(i_frame_length) > MAX_FRAME_BYTES)
               ? rcg_pkg::LEN_W'(MAX_FRAME_BYTES) : i_frame_length;
        plen_in = (len_in < rcg_pkg::LEN_W'(rcg_pkg::PREFIX_BYTES))
                ? len_in[rcg_pkg::PLEN_W-1:0] : rcg_pkg::PLEN_W'(rcg_pkg::PREFIX_BYTES);
    end

    assign admit     = !r_gated || r_hit;
    assign ring_full = (r_ring_fill == FLW'(RING_DEPTH));
    assign n_adm_cnt = r_adm_cnt + 1'b1;

    always_comb begin
        o_st.in_valid  = i_in_valid;
        o_st.need_scan = i_mode && i_coded_frame && (plen_in != '0) && (r_seen_filled != '0);
        o_st.scan_last = (FW'(r_idx) == r_seen_filled - FW'(1));
        o_st.out_free  = !r_out_valid || i_out_ready;
    end

    // prefix store: one read per scan step, one write per gated commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            {r_rd_len, r_rd_pfx} <= r_seen_mem[r_idx];
        end
        if (i_cmd.commit && r_gated) begin
            r_seen_mem[r_seen_next] <= {r_plen, r_pfx};
        end
    end

    // frame capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len   <= len_in;
            r_plen  <= plen_in;
            r_pfx   <= i_prefix_bytes & rcg_pkg::prefix_mask(plen_in);
            r_coded <= i_coded_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gated       <= 1'b0;
            r_idx         <= '0;
            r_cmp_vld     <= 1'b0;
            r_hit         <= 1'b0;
            r_seen_next   <= '0;
            r_seen_filled <= '0;
            r_ring_next   <= '0;
            r_ring_fill   <= '0;
            r_adm_cnt     <= '0;
            r_ovw_cnt     <= '0;
            r_rej_cnt     <= '0;
            r_shortest    <= '0;
            r_longest     <= '0;
            r_byte_sum    <= '0;
            r_plain_cnt   <= '0;
            r_manch_cnt   <= '0;
            r_out_valid   <= 1'b0;
            r_decision    <= 1'b0;
            r_slot        <= '0;
            r_evicted     <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_step;

            if (i_cmd.load) begin
                r_gated <= i_mode && i_coded_frame;
                r_idx   <= '0;
                r_hit   <= 1'b0;
            end else begin
                if (i_cmd.scan_step) begin
                    r_idx <= r_idx + OW'(1);
                end
                if (r_cmp_vld && (r_rd_len == r_plen) && (r_rd_pfx == r_pfx)) begin
                    r_hit <= 1'b1;
                end
            end

            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.commit) begin
                if (r_gated) begin
                    r_seen_next <= (r_seen_next == OW'(OBS_DEPTH - 1))
                                 ? '0 : r_seen_next + OW'(1);
                    if (r_seen_filled != FW'(OBS_DEPTH)) begin
                        r_seen_filled <= r_seen_filled + FW'(1);
                    end
                end

                r_decision <= !admit;
                if (admit) begin
                    r_slot    <= rcg_pkg::SLOT_W'(r_ring_next);
                    r_evicted <= ring_full;
                    if (ring_full) begin
                        r_ovw_cnt <= r_ovw_cnt + 1'b1;
                    end else begin
                        r_ring_fill <= r_ring_fill + FLW'(1);
                    end
                    r_ring_next <= (r_ring_next == RW'(RING_DEPTH - 1))
                                 ? '0 : r_ring_next + RW'(1);
                    r_adm_cnt  <= n_adm_cnt;
                    r_byte_sum <= r_byte_sum + rcg_pkg::CNT_W'(r_len);
                    if (n_adm_cnt == rcg_pkg::CNT_W'(1)) begin
                        r_shortest <= r_len;
                        r_longest  <= r_len;
                    end else begin
                        if (r_len < r_shortest) begin
                            r_shortest <= r_len;
                        end
                        if (r_len > r_longest) begin
                            r_longest <= r_len;
                        end
                    end
                    if (r_coded) begin
                        r_manch_cnt <= r_manch_cnt + 1'b1;
                    end else begin
                        r_plain_cnt <= r_plain_cnt + 1'b1;
                    end
                end else begin
                    r_slot    <= '0;
                    r_evicted <= 1'b0;
                    r_rej_cnt <= r_rej_cnt + 1'b1;
                end
            end
        end
    end

    // statistics only move on commit, which waits for the pending result to leave
    assign o_out_valid      = r_out_valid;
    assign o_decision       = r_decision;
    assign o_write_slot     = r_slot;
    assign o_evicted        = r_evicted;
    assign o_occupancy      = rcg_pkg::OCC_W'(r_ring_fill);
    assign o_inserted_total = r_adm_cnt;
    assign o_evicted_total  = r_ovw_cnt;
    assign o_rejected_total = r_rej_cnt;
    assign o_length_min     = r_shortest;
    assign o_length_max     = r_longest;
    assign o_length_sum     = r_byte_sum;
    assign o_uncoded_total  = r_plain_cnt;
    assign o_coded_total    = r_manch_cnt;

endmodule

FILE: rtl/repeat_confirm_capture_gate_core.sv
// Top level of the repeat-confirmation capture gate: sequencer plus datapath.
//
//  Channel   Dir  Modport   Contents
//  i_in      in   sink      mode, coded_frame, frame_length, prefix_bytes
//  o_out     out  source    decision, write_slot, evicted, occupancy, counters,
//                           length_min/max/sum
//
// Steps: a frame that needs no prefix lookup is accepted, then committed. A coded
// frame in gated mode with a non-empty prefix and a non-empty store scans the N
// remembered prefixes (at most OBS_DEPTH) before drain and commit; the prefix
// store has a single read port and the scan compares one entry per cycle.
// Reset: i_rst_n is synchronous, active low; it clears the counters, ring and
// store pointers. Store entries are never read before they are written.
// Stalls: the result sits in an output register, so the next frame is taken
// while it waits; commit of that frame holds until the result is taken.
module repeat_confirm_capture_gate_core #(
    parameter int RING_DEPTH      = rcg_pkg::RING_DEPTH_DEF,
    parameter int OBS_DEPTH       = rcg_pkg::OBS_DEPTH_DEF,
    parameter int MAX_FRAME_BYTES = rcg_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rcg_in_if.sink    i_in,
    rcg_out_if.source o_out
);

    rcg_pkg::t_cmd    cmd;
    rcg_pkg::t_status st;

    // sequencer: accept -> optional scan and drain -> commit
    rcg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    // ready only while idle; one frame in work at a time
    assign i_in.ready = cmd.in_ready;

    rcg_dp #(
        .RING_DEPTH      (RING_DEPTH),
        .OBS_DEPTH       (OBS_DEPTH),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_in_valid       (i_in.valid),
        .i_mode           (i_in.mode),
        .i_coded_frame    (i_in.coded_frame),
        .i_frame_length   (i_in.frame_length),
        .i_prefix_bytes   (i_in.prefix_bytes),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_decision       (o_out.decision),
        .o_write_slot     (o_out.write_slot),
        .o_evicted        (o_out.evicted),
        .o_occupancy      (o_out.occupancy),
        .o_inserted_total (o_out.inserted_total),
        .o_evicted_total  (o_out.evicted_total),
        .o_rejected_total (o_out.rejected_total),
        .o_length_min     (o_out.length_min),
        .o_length_max     (o_out.length_max),
        .o_length_sum     (o_out.length_sum),
        .o_uncoded_total  (o_out.uncoded_total),
        .o_coded_total    (o_out.coded_total)
    );

endmodule

FILE: bench/repeat_confirm_capture_gate_core_tb.sv
// Self-checking testbench for the repeat-confirmation capture gate core.
module repeat_confirm_capture_gate_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcg_pkg::*;

    // Cycle budget for the whole run. The slowest legal item scans the whole
    // prefix store, and there are random source gaps and sink stalls on top.
    localparam int CYCLE_LIMIT = 500000;
    // Quiet cycles after the last result.
    localparam int DRAIN_CYCLES = 40;
    // Prefixes that coded gated traffic keeps coming back to. Larger than the
    // prefix store so that older entries age out.
    localparam int POOL_SIZE = 20;

    // One result transaction, field for field as on the output channel.
    typedef struct packed {
        logic              decision;
        logic [SLOT_W-1:0] write_slot;
        logic              evicted;
        logic [OCC_W-1:0]  occupancy;
        logic [CNT_W-1:0]  inserted_total;
        logic [CNT_W-1:0]  evicted_total;
        logic [CNT_W-1:0]  rejected_total;
        logic [LEN_W-1:0]  length_min;
        logic [LEN_W-1:0]  length_max;
        logic [CNT_W-1:0]  length_sum;
        logic [CNT_W-1:0]  uncoded_total;
        logic [CNT_W-1:0]  coded_total;
    } gate_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rcg_in_if  in_ch ();
    rcg_out_if out_ch ();

    repeat_confirm_capture_gate_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 clk = ~clk;

    // When set, the source inserts random gaps and the sink stalls at random.
    bit pace_on = 1'b1;

    // Expected decisions, oldest first.
    gate_result_t pending_decisions[$];
    int unsigned  n_fail = 0;

    // ------------------------------------------------------------------
    // Shadow copy of the gate state.
    // ------------------------------------------------------------------
    // Prefix store: only the first seen_cnt entries are ever looked at, so
    // unwritten entries never matter.
    logic [PFX_W-1:0]  seen_pfx  [OBS_DEPTH_DEF];
    logic [PLEN_W-1:0] seen_plen [OBS_DEPTH_DEF];
    int unsigned       seen_wr   = 0;
    int unsigned       seen_cnt  = 0;
    // Ring position and fill.
    int unsigned       ring_wr   = 0;
    int unsigned       ring_cnt  = 0;
    // Running statistics; the counters and the sum wrap at 32 bits.
    logic [CNT_W-1:0]  n_admit   = '0;
    logic [CNT_W-1:0]  n_evict   = '0;
    logic [CNT_W-1:0]  n_reject  = '0;
    logic [CNT_W-1:0]  len_total = '0;
    logic [CNT_W-1:0]  n_plain   = '0;
    logic [CNT_W-1:0]  n_coded   = '0;
    logic [LEN_W-1:0]  len_lo    = '0;
    logic [LEN_W-1:0]  len_hi    = '0;

    // Prefix pool for repeat traffic.
    logic [LEN_W-1:0]  pool_len [POOL_SIZE];
    logic [PFX_W-1:0]  pool_pfx [POOL_SIZE];

    // Works out the gate decision for one frame and advances the shadow state.
    // The frame length cannot exceed the 255-byte ceiling at 8 bits, so the
    // clamp never acts.
    function automatic gate_result_t gate_decide(input logic mode, input logic coded,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [PFX_W-1:0] raw);
        gate_result_t      r;
        logic [PLEN_W-1:0] plen;
        logic [PFX_W-1:0]  pfx;
        logic              hit;
        logic              admit;
        r     = '0;
        admit = 1'b1;
        if (mode && coded) begin
            // Only the first min(len, 6) bytes take part; the rest are zeroed.
            plen = (len < PREFIX_BYTES) ? len[PLEN_W-1:0] : PLEN_W'(PREFIX_BYTES);
            pfx  = '0;
            for (int b = 0; b < PREFIX_BYTES; b++) begin
                if (b < plen) pfx[b*8 +: 8] = raw[b*8 +: 8];
            end
            // An empty prefix never confirms anything.
            hit = 1'b0;
            if (plen != 0) begin
                for (int i = 0; i < seen_cnt; i++) begin
                    if (seen_plen[i] == plen && seen_pfx[i] == pfx) hit = 1'b1;
                end
            end
            // Remembered whether it matched or not.
            seen_pfx[seen_wr]  = pfx;
            seen_plen[seen_wr] = plen;
            seen_wr = (seen_wr + 1) % OBS_DEPTH_DEF;
            if (seen_cnt < OBS_DEPTH_DEF) seen_cnt++;
            if (!hit) begin
                admit      = 1'b0;
                n_reject   = n_reject + 1'b1;
                r.decision = 1'b1;
            end
        end
        if (admit) begin
            r.write_slot = SLOT_W'(ring_wr);
            if (ring_cnt >= RING_DEPTH_DEF) begin
                n_evict   = n_evict + 1'b1;
                r.evicted = 1'b1;
            end else begin
                ring_cnt++;
            end
            ring_wr   = (ring_wr + 1) % RING_DEPTH_DEF;
            n_admit   = n_admit + 1'b1;
            len_total = len_total + CNT_W'(len);
            // First admission (or the count wrapping to one) restarts min/max.
            if (n_admit == 1) begin
                len_lo = len;
                len_hi = len;
            end else begin
                if (len < len_lo) len_lo = len;
                if (len > len_hi) len_hi = len;
            end
            if (coded) n_coded = n_coded + 1'b1;
            else       n_plain = n_plain + 1'b1;
        end
        r.occupancy      = OCC_W'(ring_cnt);
        r.inserted_total = n_admit;
        r.evicted_total  = n_evict;
        r.rejected_total = n_reject;
        r.length_min     = len_lo;
        r.length_max     = len_hi;
        r.length_sum     = len_total;
        r.uncoded_total  = n_plain;
        r.coded_total    = n_coded;
        return r;
    endfunction

    function automatic string show_result(input gate_result_t r);
        return $sformatf({"dec=%0d slot=%0d ev=%0d occ=%0d ins=%0d evt=%0d rej=%0d ",
                          "min=%0d max=%0d sum=%0d unc=%0d cod=%0d"},
                         r.decision, r.write_slot, r.evicted, r.occupancy,
                         r.inserted_total, r.evicted_total, r.rejected_total,
                         r.length_min, r.length_max, r.length_sum,
                         r.uncoded_total, r.coded_total);
    endfunction

    // Mostly short frames so that prefixes shorter than six bytes are common.
    function automatic logic [LEN_W-1:0] random_length();
        if ($urandom_range(0, 3) == 0) return LEN_W'($urandom_range(0, 255));
        return LEN_W'($urandom_range(0, 8));
    endfunction

    function automatic logic [PFX_W-1:0] random_prefix();
        return PFX_W'({$urandom, $urandom});
    endfunction

    // ------------------------------------------------------------------
    // Source side: one frame per call. Returns at the edge where the frame
    // was taken, with valid still high so back-to-back frames need no bubble.
    // ------------------------------------------------------------------
    task automatic send_frame(input logic mode, input logic coded,
                              input logic [LEN_W-1:0] len,
                              input logic [PFX_W-1:0] pfx);
        int gap;
        gap = 0;
        if (pace_on) begin
            while ($urandom_range(0, 99) < 29) gap++;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.coded_frame  <= coded;
        in_ch.frame_length <= len;
        in_ch.prefix_bytes <= pfx;
        do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        pending_decisions.push_back(gate_decide(mode, coded, len, pfx));
    endtask

    // ------------------------------------------------------------------
    // Sink side: random stalls while pacing is on, always ready otherwise.
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= pace_on ? ($urandom_range(0, 99) >= 29) : 1'b1;
        end
    end

    // Result checker: every transaction on the output channel is compared
    // with the oldest outstanding expectation.
    always @(posedge clk) begin
        gate_result_t got;
        gate_result_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.decision       = out_ch.decision;
            got.write_slot     = out_ch.write_slot;
            got.evicted        = out_ch.evicted;
            got.occupancy      = out_ch.occupancy;
            got.inserted_total = out_ch.inserted_total;
            got.evicted_total  = out_ch.evicted_total;
            got.rejected_total = out_ch.rejected_total;
            got.length_min     = out_ch.length_min;
            got.length_max     = out_ch.length_max;
            got.length_sum     = out_ch.length_sum;
            got.uncoded_total  = out_ch.uncoded_total;
            got.coded_total    = out_ch.coded_total;
            if (pending_decisions.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("ERROR: unexpected result: %s", show_result(got));
            end else begin
                want = pending_decisions.pop_front();
                if (got !== want) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("ERROR: result mismatch");
                        $display("  expected %s", show_result(want));
                        $display("  actual   %s", show_result(got));
                    end
                end
            end
        end
    end

    // Watchdog.
    initial begin
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles == CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain mode admits everything: length and prefix extremes.
    task automatic check_plain_insert();
        send_frame(1'b0, 1'b0, 8'd0,   '0);
        send_frame(1'b0, 1'b1, 8'd255, '1);
        send_frame(1'b0, 1'b0, 8'd1,   48'h0000_0000_00A5);
        send_frame(1'b0, 1'b1, 8'd6,   48'h5A5A_5A5A_5A5A);
    endtask

    // Uncoded frames bypass the gate even in gated mode.
    task automatic check_uncoded_bypass();
        send_frame(1'b1, 1'b0, 8'd6,   48'h1234_5678_9ABC);
        send_frame(1'b1, 1'b0, 8'd255, '1);
    endtask

    // First sighting rejects, a repeat admits; long frames use a six-byte
    // prefix, and a different prefix length never matches.
    task automatic check_repeat_confirm();
        send_frame(1'b1, 1'b1, 8'd6,   48'hC0DE_F00D_BEEF);
        send_frame(1'b1, 1'b1, 8'd6,   48'hC0DE_F00D_BEEF);
        send_frame(1'b1, 1'b1, 8'd200, 48'hC0DE_F00D_BEEF);
        send_frame(1'b1, 1'b1, 8'd255, '1);
        send_frame(1'b1, 1'b1, 8'd255, '1);
        send_frame(1'b1, 1'b1, 8'd5,   48'hC0DE_F00D_BEEF);
    endtask

    // Short frames: bytes past the length are ignored; empty prefixes are
    // remembered but never confirm.
    task automatic check_short_prefix();
        send_frame(1'b1, 1'b1, 8'd3, 48'h1111_11AB_CDEF);
        send_frame(1'b1, 1'b1, 8'd3, 48'h9999_99AB_CDEF);
        send_frame(1'b1, 1'b1, 8'd2, 48'h0000_0000_CDEF);
        send_frame(1'b1, 1'b1, 8'd0, '0);
        send_frame(1'b1, 1'b1, 8'd0, '1);
    endtask

    // Mixed traffic. Most of it is coded gated frames drawn from a pool of
    // prefixes so that confirmations, misses and store aging all happen; the
    // rest is plain, uncoded and fully random coded noise.
    task automatic run_mixed_traffic(input int count);
        int               pick;
        int               k;
        logic [LEN_W-1:0] len;
        logic [PFX_W-1:0] pfx;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                send_frame(1'b0, 1'($urandom_range(0, 1)), random_length(),
                           random_prefix());
            end else if (pick < 35) begin
                send_frame(1'b1, 1'b0, random_length(), random_prefix());
            end else if (pick < 88) begin
                k = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 9) == 0) begin
                    pool_len[k] = random_length();
                    pool_pfx[k] = random_prefix();
                end
                // Any length of six or more gives the same prefix.
                len = pool_len[k];
                if (len >= PREFIX_BYTES) len = LEN_W'($urandom_range(PREFIX_BYTES, 255));
                // Fresh junk above the prefix bytes every time.
                pfx = random_prefix();
                for (int b = 0; b < PREFIX_BYTES; b++) begin
                    if (b < len) pfx[b*8 +: 8] = pool_pfx[k][b*8 +: 8];
                end
                send_frame(1'b1, 1'b1, len, pfx);
            end else begin
                send_frame(1'b1, 1'b1, random_length(), random_prefix());
            end
        end
    endtask

    // Same traffic with no source gaps and no sink stalls.
    task automatic run_back_to_back(input int count);
        pace_on = 1'b0;
        run_mixed_traffic(count);
        pace_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        in_ch.valid        = 1'b0;
        in_ch.mode         = 1'b0;
        in_ch.coded_frame  = 1'b0;
        in_ch.frame_length = '0;
        in_ch.prefix_bytes = '0;
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_len[k] = LEN_W'($urandom_range(1, 8));
            pool_pfx[k] = random_prefix();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_plain_insert();
        check_uncoded_bypass();
        check_repeat_confirm();
        check_short_prefix();
        run_mixed_traffic(400);
        run_back_to_back(250);
        run_mixed_traffic(350);

        // Drain: wait for every outstanding result, then a quiet tail to
        // catch anything extra.
        in_ch.valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/rcg_pkg.sv
rtl/rcg_in_if.sv
rtl/rcg_out_if.sv
rtl/rcg_ctrl.sv
rtl/rcg_dp.sv
rtl/repeat_confirm_capture_gate_core.sv
bench/repeat_confirm_capture_gate_core_tb.sv
